// ===== design/mdr_pkg.sv =====
package mdr_pkg;

	localparam int MAX_AGENTS  = 32;
	localparam int COORD_W     = 10;
	localparam int DIST_W      = COORD_W + 1;
	localparam int IDX_W       = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
	localparam int CNT_W       = $clog2(MAX_AGENTS + 1);
	localparam int OUT_W       = 5;

	// popcount of the compare vector is split into groups, summed one stage later
	localparam int GROUP_SIZE  = 8;
	localparam int NUM_GROUPS  = (MAX_AGENTS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PART_W      = $clog2(GROUP_SIZE + 1);

	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
	localparam int QUEUE_CW    = QUEUE_AW + 1;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              last;
	} agent_entry_t;

	typedef enum logic {
		BACK_LOAD,
		BACK_EMIT
	} back_state_t;

endpackage

// ===== design/mdr_agent_if.sv =====
interface mdr_agent_if;
	logic                       valid;
	logic                       ready;
	logic [mdr_pkg::COORD_W-1:0] start_row;
	logic [mdr_pkg::COORD_W-1:0] start_col;
	logic [mdr_pkg::COORD_W-1:0] goal_row;
	logic [mdr_pkg::COORD_W-1:0] goal_col;
	logic                       final_agent;

	modport source (
		output valid, start_row, start_col, goal_row, goal_col, final_agent,
		input  ready
	);
	modport sink (
		input  valid, start_row, start_col, goal_row, goal_col, final_agent,
		output ready
	);
endinterface

// ===== design/mdr_rank_if.sv =====
interface mdr_rank_if;
	logic                      valid;
	logic                      ready;
	logic [mdr_pkg::OUT_W-1:0] agent_number;
	logic [mdr_pkg::OUT_W-1:0] agent_rank;
	logic                      run_end;
	logic                      dropped_agents;

	modport source (
		output valid, agent_number, agent_rank, run_end, dropped_agents,
		input  ready
	);
	modport sink (
		input  valid, agent_number, agent_rank, run_end, dropped_agents,
		output ready
	);
endinterface

// ===== design/mdr_front.sv =====
module mdr_front (
	mdr_agent_if.sink              agents,
	input  logic                   full,
	output logic                   push,
	output mdr_pkg::agent_entry_t  entry
);

	logic [mdr_pkg::COORD_W-1:0] row_diff;
	logic [mdr_pkg::COORD_W-1:0] col_diff;

	// absolute differences, then the manhattan sum
	always_comb begin
		if (agents.start_row > agents.goal_row) begin
			row_diff = agents.start_row - agents.goal_row;
		end else begin
			row_diff = agents.goal_row - agents.start_row;
		end
		if (agents.start_col > agents.goal_col) begin
			col_diff = agents.start_col - agents.goal_col;
		end else begin
			col_diff = agents.goal_col - agents.start_col;
		end
		entry.distance = mdr_pkg::DIST_W'(row_diff) + mdr_pkg::DIST_W'(col_diff);
		entry.last     = agents.final_agent;
	end

	assign agents.ready = !full;
	assign push         = agents.valid && !full;

endmodule

// ===== design/mdr_queue.sv =====
module mdr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mdr_pkg::agent_entry_t  push_data,
	output logic                   full,
	input  logic                   pop,
	output mdr_pkg::agent_entry_t  pop_data,
	output logic                   empty
);

	mdr_pkg::agent_entry_t             entries_q [mdr_pkg::QUEUE_DEPTH];
	logic [mdr_pkg::QUEUE_AW-1:0]      wr_ptr_q;
	logic [mdr_pkg::QUEUE_AW-1:0]      rd_ptr_q;
	logic [mdr_pkg::QUEUE_CW-1:0]      fill_q;
	logic                              do_push;
	logic                              do_pop;

	assign full     = fill_q == mdr_pkg::QUEUE_CW'(mdr_pkg::QUEUE_DEPTH);
	assign empty    = fill_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + mdr_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + mdr_pkg::QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + mdr_pkg::QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - mdr_pkg::QUEUE_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/mdr_back.sv =====
module mdr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   order_mode,
	input  mdr_pkg::agent_entry_t  entry,
	input  logic                   empty,
	output logic                   pop,
	mdr_rank_if.source             ranks
);

	localparam int PAD_W = mdr_pkg::NUM_GROUPS * mdr_pkg::GROUP_SIZE;

	mdr_pkg::back_state_t          state_q;
	mdr_pkg::back_state_t          state_d;
	logic [mdr_pkg::CNT_W-1:0]     count_q;
	logic                          overflow_q;
	logic [mdr_pkg::IDX_W-1:0]     emit_idx_q;

	// one cell per agent: stored distance and running rank
	logic [mdr_pkg::DIST_W-1:0]    dist_q [mdr_pkg::MAX_AGENTS];
	logic [mdr_pkg::IDX_W-1:0]     rank_q [mdr_pkg::MAX_AGENTS];

	logic                          valid_s1;
	logic [mdr_pkg::IDX_W-1:0]     slot_s1;
	logic [mdr_pkg::PART_W-1:0]    part_s1 [mdr_pkg::NUM_GROUPS];

	logic                          out_valid_q;
	logic [mdr_pkg::OUT_W-1:0]     number_q;
	logic [mdr_pkg::OUT_W-1:0]     order_q;
	logic                          run_end_q;
	logic                          dropped_q;

	logic                          full_store;
	logic                          store;
	logic                          out_load;
	logic                          last_emit;
	logic [PAD_W-1:0]              le_vec;
	logic [mdr_pkg::MAX_AGENTS-1:0] gt_vec;
	logic [mdr_pkg::PART_W-1:0]    part_d [mdr_pkg::NUM_GROUPS];
	logic [mdr_pkg::CNT_W-1:0]     base_sum;
	logic [mdr_pkg::IDX_W-1:0]     new_rank;
	logic [mdr_pkg::IDX_W-1:0]     rank_sel;
	logic [mdr_pkg::CNT_W-1:0]     rank_rev;
	logic [mdr_pkg::IDX_W-1:0]     rank_out;

	assign full_store = count_q == mdr_pkg::CNT_W'(mdr_pkg::MAX_AGENTS);
	assign store      = pop && !full_store;
	assign last_emit  = (mdr_pkg::CNT_W'(emit_idx_q) + mdr_pkg::CNT_W'(1)) == count_q;

	// cell compares against the incoming distance
	always_comb begin
		le_vec = '0;
		gt_vec = '0;
		for (int i = 0; i < mdr_pkg::MAX_AGENTS; i++) begin
			if (store && (mdr_pkg::CNT_W'(i) < count_q)) begin
				le_vec[i] = dist_q[i] <= entry.distance;
				gt_vec[i] = dist_q[i] > entry.distance;
			end
		end
	end

	// group popcounts, registered into stage 1
	always_comb begin
		for (int g = 0; g < mdr_pkg::NUM_GROUPS; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < mdr_pkg::GROUP_SIZE; k++) begin
				part_d[g] = part_d[g] + mdr_pkg::PART_W'(le_vec[g * mdr_pkg::GROUP_SIZE + k]);
			end
		end
	end

	// stage 2: the new cell's rank, plus any bump from the item in this cycle
	always_comb begin
		base_sum = '0;
		for (int g = 0; g < mdr_pkg::NUM_GROUPS; g++) begin
			base_sum = base_sum + mdr_pkg::CNT_W'(part_s1[g]);
		end
		new_rank = base_sum[mdr_pkg::IDX_W-1:0] + mdr_pkg::IDX_W'(gt_vec[slot_s1]);
	end

	always_comb begin
		rank_sel = rank_q[emit_idx_q];
		rank_rev = count_q - mdr_pkg::CNT_W'(1) - mdr_pkg::CNT_W'(rank_sel);
		rank_out = order_mode ? rank_rev[mdr_pkg::IDX_W-1:0] : rank_sel;
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			mdr_pkg::BACK_LOAD: begin
				pop = !empty;
				if (pop && entry.last) begin
					state_d = mdr_pkg::BACK_EMIT;
				end
			end
			mdr_pkg::BACK_EMIT: begin
				out_load = !valid_s1 && (!out_valid_q || ranks.ready);
				if (out_load && last_emit) begin
					state_d = mdr_pkg::BACK_LOAD;
				end
			end
			default: begin
				state_d = mdr_pkg::BACK_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mdr_pkg::BACK_LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			emit_idx_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= store;
			if (store) begin
				count_q <= count_q + mdr_pkg::CNT_W'(1);
			end else if (out_load && last_emit) begin
				count_q <= '0;
			end
			if (pop && full_store) begin
				overflow_q <= 1'b1;
			end else if (out_load && last_emit) begin
				overflow_q <= 1'b0;
			end
			if (out_load) begin
				emit_idx_q <= last_emit ? '0 : emit_idx_q + mdr_pkg::IDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (ranks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			dist_q[count_q[mdr_pkg::IDX_W-1:0]] <= entry.distance;
			slot_s1 <= count_q[mdr_pkg::IDX_W-1:0];
			part_s1 <= part_d;
		end
		for (int i = 0; i < mdr_pkg::MAX_AGENTS; i++) begin
			if (valid_s1 && (slot_s1 == mdr_pkg::IDX_W'(i))) begin
				rank_q[i] <= new_rank;
			end else if (gt_vec[i]) begin
				rank_q[i] <= rank_q[i] + mdr_pkg::IDX_W'(1);
			end
		end
		if (out_load) begin
			number_q  <= mdr_pkg::OUT_W'(emit_idx_q);
			order_q   <= mdr_pkg::OUT_W'(rank_out);
			run_end_q <= last_emit;
			dropped_q <= overflow_q;
		end
	end

	assign ranks.valid          = out_valid_q;
	assign ranks.agent_number   = number_q;
	assign ranks.agent_rank     = order_q;
	assign ranks.run_end        = run_end_q;
	assign ranks.dropped_agents = dropped_q;

`ifndef ASSERT_OFF
	a_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (mdr_pkg::CNT_W'(slot_s1) < count_q))
		else $error("pending rank slot outside the stored set");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		store |=> (count_q == $past(count_q) + mdr_pkg::CNT_W'(1)))
		else $error("agent count did not advance on a stored agent");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdr_pkg::BACK_EMIT && state_d == mdr_pkg::BACK_LOAD)
		|=> (count_q == '0 && !overflow_q))
		else $error("set not cleared after its last rank");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdr_pkg::BACK_EMIT) |-> (count_q != '0))
		else $error("emitting ranks for an empty set");
`endif

endmodule

// ===== design/manhattan_distance_ranker_unit.sv =====
// channel   dir  handshake      payload
// agents    in   valid/ready    start_row, start_col, goal_row, goal_col, final_agent
// ranks     out  valid/ready    agent_number, agent_rank, run_end, dropped_agents
// cfg       in   cfg_write      cfg_data -> order_mode
//
// agents load one per cycle while the queue has room; a set emits one rank per stored
// agent (at most 32), one per cycle while ranks.ready is high, after the last stored
// cell's rank settles; the rate is set by the back end's one-agent-per-cycle cell
// update and rank read; the two-entry queue takes up to two agents while ranks drain
// asynchronous active-low reset clears the queue, the set count, the drop flag and
// order_mode; stored distances carry no reset
// a stall on ranks holds the output register and the back end; agents.ready drops
// only once the queue is full
module manhattan_distance_ranker_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic          cfg_data,
	mdr_agent_if.sink     agents,
	mdr_rank_if.source    ranks
);

	// order_mode register: 0 ascending, 1 fully reversed
	logic                  order_mode_q;

	// front to queue
	logic                  push;
	mdr_pkg::agent_entry_t push_entry;
	logic                  full;

	// queue to back
	logic                  pop;
	mdr_pkg::agent_entry_t pop_entry;
	logic                  empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b0;
		end else if (cfg_write) begin
			order_mode_q <= cfg_data;
		end
	end

	// front: take the agent and compute its manhattan distance
	mdr_front u_front (
		.agents (agents),
		.full   (full),
		.push   (push),
		.entry  (push_entry)
	);

	// short queue so the front and back stall on their own
	mdr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_entry),
		.empty     (empty)
	);

	// back: per-agent rank cells and the rank emitter
	mdr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.order_mode (order_mode_q),
		.entry      (pop_entry),
		.empty      (empty),
		.pop        (pop),
		.ranks      (ranks)
	);

endmodule

// ===== verif/mdr_rank_checker.sv =====
module mdr_rank_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic cfg_data,
	mdr_agent_if agents,
	mdr_rank_if  ranks,
	output int   errors,
	output int   ranks_pending,
	output int   ranks_checked,
	output int   sets_ranked,
	output int   overflow_sets
);
	timeunit 1ns;
	timeprecision 1ps;

	import mdr_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] number;
		logic [OUT_W-1:0] rank;
		logic             run_end;
		logic             dropped;
	} rank_item_t;

	logic [DIST_W-1:0] distance_ram [MAX_AGENTS];
	int unsigned       stored_agents;
	logic              capacity_hit;
	logic              reverse_order;
	rank_item_t        expected_ranks [$];

	function automatic logic [DIST_W-1:0] grid_distance(
		input logic [COORD_W-1:0] sr, sc, gr, gc);
		int row_gap;
		int col_gap;
		row_gap = (sr > gr) ? int'(sr) - int'(gr) : int'(gr) - int'(sr);
		col_gap = (sc > gc) ? int'(sc) - int'(gc) : int'(gc) - int'(sc);
		return DIST_W'(row_gap + col_gap);
	endfunction

	task automatic flag_error(input string msg);
		$display("[%0t] rank check: %s", $time, msg);
		errors++;
	endtask

	// key is (distance, arrival index); reversed order flips the whole ranking
	task automatic queue_set_ranks();
		int unsigned i;
		int unsigned j;
		int unsigned below;
		rank_item_t  r;
		for (i = 0; i < stored_agents; i++) begin
			below = 0;
			for (j = 0; j < stored_agents; j++) begin
				if (distance_ram[j] < distance_ram[i] ||
				    (distance_ram[j] == distance_ram[i] && j < i))
					below++;
			end
			if (reverse_order)
				below = stored_agents - 1 - below;
			r.number  = OUT_W'(i);
			r.rank    = OUT_W'(below);
			r.run_end = (i + 1 == stored_agents);
			r.dropped = capacity_hit;
			expected_ranks.push_back(r);
		end
		sets_ranked++;
		if (capacity_hit)
			overflow_sets++;
		stored_agents = 0;
		capacity_hit  = 1'b0;
	endtask

	task automatic check_rank();
		rank_item_t want;
		if (expected_ranks.size() == 0) begin
			flag_error($sformatf("unexpected item: agent %0d rank %0d",
				ranks.agent_number, ranks.agent_rank));
			return;
		end
		want = expected_ranks.pop_front();
		ranks_checked++;
		if (ranks.agent_number !== want.number)
			flag_error($sformatf("agent_number got %0d want %0d",
				ranks.agent_number, want.number));
		if (ranks.agent_rank !== want.rank)
			flag_error($sformatf("agent %0d: agent_rank got %0d want %0d",
				want.number, ranks.agent_rank, want.rank));
		if (ranks.run_end !== want.run_end)
			flag_error($sformatf("agent %0d: run_end got %0b want %0b",
				want.number, ranks.run_end, want.run_end));
		if (ranks.dropped_agents !== want.dropped)
			flag_error($sformatf("agent %0d: dropped_agents got %0b want %0b",
				want.number, ranks.dropped_agents, want.dropped));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_agents = 0;
			capacity_hit  = 1'b0;
			reverse_order = 1'b0;
			expected_ranks.delete();
			errors        = 0;
			ranks_checked = 0;
			sets_ranked   = 0;
			overflow_sets = 0;
		end else begin
			if (cfg_write)
				reverse_order = cfg_data;
			// drain side first: a set's ranks never leave on the edge that closes it
			if (ranks.valid && ranks.ready)
				check_rank();
			if (agents.valid && agents.ready) begin
				if (stored_agents < MAX_AGENTS) begin
					distance_ram[stored_agents] = grid_distance(agents.start_row,
						agents.start_col, agents.goal_row, agents.goal_col);
					stored_agents++;
				end else begin
					capacity_hit = 1'b1;
				end
				if (agents.final_agent)
					queue_set_ranks();
			end
		end
		ranks_pending = expected_ranks.size();
	end

endmodule

// ===== verif/manhattan_distance_ranker_unit_tb.sv =====
module manhattan_distance_ranker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mdr_pkg::*;

	// well above the slowest legal run of the 127 agents sent here
	localparam int CYCLE_LIMIT  = 100000;
	// cycles allowed after the last rank before the verdict or a mode write
	localparam int DRAIN_CYCLES = 16;

	localparam logic [COORD_W-1:0] CMAX = '1;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_data;

	mdr_agent_if agent_ch ();
	mdr_rank_if  rank_ch ();

	int errors;
	int ranks_pending;
	int ranks_checked;
	int sets_ranked;
	int overflow_sets;
	int agents_sent       = 0;
	int cycle_count       = 0;
	bit no_idle           = 1'b0;   // both sides run without gaps while set
	int rank_hold_cycles  = 0;      // long receiver hold-off, taken by the receiver

	manhattan_distance_ranker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.agents    (agent_ch),
		.ranks     (rank_ch)
	);

	// watches both channels, predicts every rank and compares
	mdr_rank_checker rank_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.agents        (agent_ch),
		.ranks         (rank_ch),
		.errors        (errors),
		.ranks_pending (ranks_pending),
		.ranks_checked (ranks_checked),
		.sets_ranked   (sets_ranked),
		.overflow_sets (overflow_sets)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs or a rank never shows up
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d ranks still expected",
				cycle_count, ranks_pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// coordinates biased toward the ends of the range and toward ties
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom_range(0, 1023));
			1: return COORD_W'($urandom_range(0, 3));
			2: return CMAX - COORD_W'($urandom_range(0, 3));
			default: return ($urandom_range(0, 1) == 1) ? CMAX : '0;
		endcase
	endfunction

	// one agent item; valid stays high after acceptance so back-to-back items
	// need no drop, callers that stop sending lower it at the next falling edge
	task automatic send_agent(input logic [COORD_W-1:0] sr, sc, gr, gc,
		input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			agent_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		agent_ch.start_row   = sr;
		agent_ch.start_col   = sc;
		agent_ch.goal_row    = gr;
		agent_ch.goal_col    = gc;
		agent_ch.final_agent = last;
		agent_ch.valid       = 1'b1;
		do @(posedge clk); while (!agent_ch.ready);
		agents_sent++;
	endtask

	// a whole set of random agents, the last one marked final
	task automatic send_set(input int n);
		int k;
		for (k = 0; k < n; k++)
			send_agent(rand_coord(), rand_coord(), rand_coord(), rand_coord(), k == n - 1);
	endtask

	// sender goes quiet until every expected rank has come out
	task automatic pause_for_ranks();
		@(negedge clk);
		agent_ch.valid = 1'b0;
		wait (ranks_pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mode write only with the block idle
	task automatic set_order(input logic reversed);
		pause_for_ranks();
		cfg_data  = reversed;
		cfg_write = 1'b1;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// optional large set (full store or overflow) then small sets
	task automatic random_phase(input int small_items, input int big_set);
		int sent;
		int n;
		if (big_set > 0)
			send_set(big_set);
		sent = 0;
		while (sent < small_items) begin
			n = $urandom_range(1, 8);
			if (n > small_items - sent)
				n = small_items - sent;
			send_set(n);
			sent += n;
		end
	endtask

	// rank receiver: random stall per item, plus the long hold-off on request
	initial begin
		int stall;
		rank_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rank_hold_cycles > 0) begin
				rank_ch.ready = 1'b0;
				repeat (rank_hold_cycles) @(negedge clk);
				rank_hold_cycles = 0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				rank_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rank_ch.ready = 1'b1;
			// leave the wait early when a hold-off is requested
			do @(posedge clk); while (!rank_ch.valid && rank_hold_cycles == 0);
		end
	end

	// stimulus
	initial begin
		arst_n               = 1'b0;
		cfg_write            = 1'b0;
		cfg_data             = 1'b0;
		agent_ch.valid       = 1'b0;
		agent_ch.start_row   = '0;
		agent_ch.start_col   = '0;
		agent_ch.goal_row    = '0;
		agent_ch.goal_col    = '0;
		agent_ch.final_agent = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ascending order straight out of reset
		// single-agent set with zero distance
		send_agent('0, '0, '0, '0, 1'b1);
		// largest distances with ties, a zero distance and the corner swaps
		send_agent(CMAX, CMAX, '0, '0, 1'b0);
		send_agent('0, '0, CMAX, CMAX, 1'b0);
		send_agent('0, CMAX, CMAX, '0, 1'b0);
		send_agent(10'd5, 10'd5, 10'd5, 10'd5, 1'b0);
		send_agent(CMAX, '0, '0, CMAX, 1'b1);

		// reversed order on the same extremes
		set_order(1'b1);
		send_agent(CMAX, CMAX, '0, '0, 1'b0);
		send_agent('0, '0, CMAX, CMAX, 1'b0);
		send_agent('0, CMAX, CMAX, '0, 1'b0);
		send_agent(10'd5, 10'd5, 10'd5, 10'd5, 1'b0);
		send_agent(CMAX, '0, '0, CMAX, 1'b1);
		send_agent(CMAX, CMAX, CMAX, CMAX, 1'b1);
		// all-equal distances, so only the arrival index orders them
		send_agent(10'd3, 10'd3, 10'd4, 10'd4, 1'b0);
		send_agent(10'd4, 10'd4, 10'd3, 10'd3, 1'b0);
		send_agent(10'd0, 10'd2, 10'd0, 10'd0, 1'b0);
		send_agent(10'd9, 10'd9, 10'd9, 10'd11, 1'b1);

		// random sets, reversed order
		random_phase(12, 0);

		// receiver holds off while the sender bursts, so the input stalls
		pause_for_ranks();
		rank_hold_cycles = 300;
		no_idle          = 1'b1;
		send_set(5);
		send_set(6);
		send_set(5);
		no_idle = 1'b0;

		// ascending, with a set whose final agent lands beyond capacity
		set_order(1'b0);
		random_phase(8, MAX_AGENTS + 1);

		// reversed, larger overflow
		set_order(1'b1);
		random_phase(8, MAX_AGENTS + 2);

		pause_for_ranks();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d agents in %0d sets, %0d ranks checked", agents_sent,
			sets_ranked, ranks_checked);
		$display("both orders, full store and %0d sets with dropped agents", overflow_sets);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
